FILE: src/i2cseq_pkg.sv
// Types and codes shared by the I2C transfer sequencer modules.
package i2cseq_pkg;

    localparam int TDATA_IN_W  = 40;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 32;

    // Request kinds carried in the input tuser
    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Controller command codes
    localparam logic [2:0] CMD_SINGLE_SEND = 3'd0;
    localparam logic [2:0] CMD_SEND_START  = 3'd1;
    localparam logic [2:0] CMD_SEND_CONT   = 3'd2;
    localparam logic [2:0] CMD_SEND_FINISH = 3'd3;
    localparam logic [2:0] CMD_SINGLE_RECV = 3'd4;
    localparam logic [2:0] CMD_RECV_START  = 3'd5;
    localparam logic [2:0] CMD_RECV_CONT   = 3'd6;
    localparam logic [2:0] CMD_RECV_FINISH = 3'd7;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_WR_NEXT  = 10'b00_0000_0010,
        PH_WR_FINAL = 10'b00_0000_0100,
        PH_WAIT_ACK = 10'b00_0000_1000,
        PH_SEND_ACK = 10'b00_0001_0000,
        PH_RD_ONE   = 10'b00_0010_0000,
        PH_RD_FIRST = 10'b00_0100_0000,
        PH_RD_NEXT  = 10'b00_1000_0000,
        PH_RD_FINAL = 10'b01_0000_0000,
        PH_RD_WAIT  = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       bus_error;
        logic [7:0] byte_count;
        logic [7:0] reg_offset;
        logic [6:0] slave_addr;
        logic [1:0] req_type;
    } t_in_item;

    // Packed so that the first field lands in the highest bits
    typedef struct packed {
        logic       rejected;
        logic       now_idle;
        logic [7:0] rx_out;
        logic       rx_valid;
        logic [7:0] data_out;
        logic       data_out_valid;
        logic       read_mode;
        logic [6:0] bus_addr;
        logic [2:0] cmd_code;
        logic       cmd_valid;
    } t_result;

endpackage

FILE: src/i2cseq_step.sv
// Next-phase and command decision for one request or completion event.
module i2cseq_step import i2cseq_pkg::*; #(
    parameter int COUNT_WIDTH = 8
) (
    input  t_in_item               i_item,
    input  t_phase                 i_phase,
    input  logic [COUNT_WIDTH-1:0] i_remaining,
    input  logic [6:0]             i_target_addr,
    output t_result                o_result,
    output t_phase                 o_phase,
    output logic [COUNT_WIDTH-1:0] o_remaining,
    output logic [6:0]             o_target_addr
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);

    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] rem_dec;
    logic                   busy;

    assign cnt     = COUNT_WIDTH'(i_item.byte_count);
    assign rem_dec = i_remaining - CNT_ONE;
    assign busy    = (i_phase != PH_IDLE) && (i_phase != PH_WR_NEXT) &&
                     (i_phase != PH_WR_FINAL) && (i_phase != PH_WAIT_ACK) &&
                     (i_phase != PH_SEND_ACK) && (i_phase != PH_RD_ONE) &&
                     (i_phase != PH_RD_FIRST) && (i_phase != PH_RD_NEXT) &&
                     (i_phase != PH_RD_FINAL) && (i_phase != PH_RD_WAIT)
                     ? 1'b0 : (i_phase != PH_IDLE);

    always_comb begin
        o_result      = '0;
        o_phase       = busy ? i_phase : PH_IDLE;
        o_remaining   = i_remaining;
        o_target_addr = i_target_addr;

        if (i_item.req_type == REQ_READ || i_item.req_type == REQ_WRITE) begin
            if (busy || cnt == '0) begin
                o_result.rejected = 1'b1;
            end else begin
                o_target_addr            = i_item.slave_addr;
                o_remaining              = cnt;
                o_result.cmd_valid       = 1'b1;
                o_result.bus_addr        = i_item.slave_addr;
                o_result.data_out_valid  = 1'b1;
                o_result.data_out        = i_item.reg_offset;
                if (i_item.req_type == REQ_READ) begin
                    o_phase           = (cnt == CNT_ONE) ? PH_RD_ONE : PH_RD_FIRST;
                    o_result.cmd_code = CMD_SINGLE_SEND;
                end else begin
                    o_phase           = (cnt == CNT_ONE) ? PH_WR_FINAL : PH_WR_NEXT;
                    o_result.cmd_code = CMD_SEND_START;
                end
            end
        end else if (i_item.req_type == REQ_EVENT) begin
            o_result.bus_addr = i_target_addr;
            case (i_phase)
                PH_WR_NEXT: begin
                    o_result.cmd_valid      = 1'b1;
                    o_result.cmd_code       = CMD_SEND_CONT;
                    o_result.data_out_valid = 1'b1;
                    o_result.data_out       = i_item.tx_byte;
                    o_remaining             = rem_dec;
                    if (rem_dec == CNT_ONE) begin
                        o_phase = PH_WR_FINAL;
                    end
                end
                PH_WR_FINAL: begin
                    o_result.cmd_valid      = 1'b1;
                    o_result.cmd_code       = CMD_SEND_FINISH;
                    o_result.data_out_valid = 1'b1;
                    o_result.data_out       = i_item.tx_byte;
                    o_remaining             = rem_dec;
                    o_phase                 = PH_SEND_ACK;
                end
                PH_WAIT_ACK: begin
                    // keep polling until the slave answers without error
                    if (i_item.bus_error) begin
                        o_result.cmd_valid = 1'b1;
                        o_result.cmd_code  = CMD_SINGLE_RECV;
                        o_result.read_mode = 1'b1;
                    end else begin
                        o_phase = PH_IDLE;
                    end
                end
                PH_SEND_ACK: begin
                    o_result.cmd_valid = 1'b1;
                    o_result.cmd_code  = CMD_SINGLE_RECV;
                    o_result.read_mode = 1'b1;
                    o_phase            = PH_WAIT_ACK;
                end
                PH_RD_ONE: begin
                    o_result.cmd_valid = 1'b1;
                    o_result.cmd_code  = CMD_SINGLE_RECV;
                    o_result.read_mode = 1'b1;
                    o_phase            = PH_RD_WAIT;
                end
                PH_RD_FIRST: begin
                    o_result.cmd_valid = 1'b1;
                    o_result.cmd_code  = CMD_RECV_START;
                    o_result.read_mode = 1'b1;
                    o_phase = (i_remaining == CNT_TWO) ? PH_RD_FINAL : PH_RD_NEXT;
                end
                PH_RD_NEXT: begin
                    o_result.cmd_valid = 1'b1;
                    o_result.cmd_code  = CMD_RECV_CONT;
                    o_result.read_mode = 1'b1;
                    o_result.rx_valid  = 1'b1;
                    o_result.rx_out    = i_item.rx_byte;
                    o_remaining        = rem_dec;
                    if (rem_dec == CNT_TWO) begin
                        o_phase = PH_RD_FINAL;
                    end
                end
                PH_RD_FINAL: begin
                    o_result.cmd_valid = 1'b1;
                    o_result.cmd_code  = CMD_RECV_FINISH;
                    o_result.read_mode = 1'b1;
                    o_result.rx_valid  = 1'b1;
                    o_result.rx_out    = i_item.rx_byte;
                    o_remaining        = rem_dec;
                    o_phase            = PH_RD_WAIT;
                end
                PH_RD_WAIT: begin
                    o_result.rx_valid = 1'b1;
                    o_result.rx_out   = i_item.rx_byte;
                    o_remaining       = rem_dec;
                    o_phase           = PH_IDLE;
                end
                default: begin
                end
            endcase
            // address field reads zero when no command goes out
            if (!o_result.cmd_valid) begin
                o_result.bus_addr = '0;
            end
        end

        o_result.now_idle = (o_phase == PH_IDLE);
    end

endmodule

FILE: src/i2c_master_transfer_sequencer.sv
// Top level of the I2C master register-offset transfer sequencer.
//
// Input stream (s_axis): one transfer per start request or controller
// completion event; tuser carries the request kind (event, start read,
// start write), tdata carries address, offset, count, error flag and bytes.
// Output stream (m_axis): exactly one result per input transfer, holding
// the next controller command, the byte placed in the data register, a
// received byte for the read buffer, and idle / rejected flags.
// The result passes through the input register and then the result register
// before it shows on m_axis. Throughput: one item per cycle while the
// receiver does not stall, set by the combinational phase decision between
// the two registers.
// Reset clears the phase to idle, the remaining count and the latched
// address, and empties both register stages.
// When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready drops only once both stages are occupied.
module i2c_master_transfer_sequencer import i2cseq_pkg::*; #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [6:0] slave_addr, [14:7] reg_offset, [22:15] byte_count,
    // [23] bus_error, [31:24] rx_byte, [39:32] tx_byte
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] cmd_valid, [3:1] cmd_code, [10:4] bus_addr, [11] read_mode,
    // [12] data_out_valid, [20:13] data_out, [21] rx_valid, [29:22] rx_out,
    // [30] now_idle, [31] rejected
    output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic                   r_in_valid;
    t_in_item               r_in;
    t_phase                 r_phase;
    logic [COUNT_WIDTH-1:0] r_remaining;
    logic [6:0]             r_target_addr;
    logic                   r_out_valid;
    t_result                r_out;

    t_result                n_out;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] n_remaining;
    logic [6:0]             n_target_addr;
    logic                   advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    i2cseq_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_item        (r_in),
        .i_phase       (r_phase),
        .i_remaining   (r_remaining),
        .i_target_addr (r_target_addr),
        .o_result      (n_out),
        .o_phase       (n_phase),
        .o_remaining   (n_remaining),
        .o_target_addr (n_target_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_IDLE;
            r_remaining   <= '0;
            r_target_addr <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_remaining   <= n_remaining;
                r_target_addr <= n_target_addr;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= {s_axis_tdata, s_axis_tuser};
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
